@@ rtl/vector3_normalize_defines.svh @@
// Assertion macros shared by the vector normalizer RTL.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
// Implication checked every clock edge outside reset.
`define V3N_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define V3N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/v3n_pkg.sv @@
// Package: types, widths and constants for the vector normalizer.
package v3n_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int IN_W = 32;
   localparam int MAG_W = 32;
   localparam int SUM_W = 64;
   localparam int LEN_W = 32;
   localparam int UNIT_W = 18;
   localparam int MINLEN_W = 16;
   localparam logic [17:0] UNIT_MAX_MAG = 18'd131071;
   localparam logic [0:0] REG_MIN_LENGTH = 1'b0;

   // Sideband that travels alongside the arithmetic in every root cell.
   typedef struct packed {
      logic       neg_x;
      logic       neg_y;
      logic       neg_z;
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [MAG_W-1:0] mag_z;
   } vec_type;
endpackage

@@ rtl/v3n_stream_if.sv @@
// Valid/ready stream interfaces for the request and response channels.
interface v3n_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] x_in;
   logic signed [31:0] y_in;
   logic signed [31:0] z_in;
   modport source (output valid, x_in, y_in, z_in, input ready);
   modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

interface v3n_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [17:0] unit_x;
   logic signed [17:0] unit_y;
   logic signed [17:0] unit_z;
   logic [31:0] length;
   logic        degenerate;
   modport source (output valid, unit_x, unit_y, unit_z, length, degenerate, input ready);
   modport sink (input valid, unit_x, unit_y, unit_z, length, degenerate, output ready);
endinterface

@@ rtl/v3n_sqrt_cell.sv @@
// One cell of the square root chain: resolves one root bit per cycle while advance is high.
module v3n_sqrt_cell (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [63:0]            rem_in,
   input  logic [31:0]            root_in,
   input  v3n_pkg::vec_type       vec_in,
   output logic [63:0]            rem_out,
   output logic [31:0]            root_out,
   output v3n_pkg::vec_type       vec_out
);
   parameter int STEP = 0;
   import v3n_pkg::*;
   // Restoring method: root bit STEP counted from the top.
   localparam int BITPOS = 31 - STEP;
   logic [63:0] rem_ff, rem_in_c;
   logic [31:0] root_ff, root_in_c;
   vec_type     vec_ff;
   logic [64:0] test;

   always_comb begin
      // (2*root*2^b + 2^(2b)) expressed with root holding upper bits
      test = ({33'd0, root_in} << (BITPOS + 1)) + (65'd1 << (2 * BITPOS));
      if ({1'b0, rem_in} >= test) begin
         rem_in_c  = rem_in - test[63:0];
         root_in_c = root_in | (32'd1 << BITPOS);
      end else begin
         rem_in_c  = rem_in;
         root_in_c = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in_c;
         root_ff <= root_in_c;
         vec_ff  <= vec_in;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign vec_out  = vec_ff;
endmodule

@@ rtl/v3n_div_cell.sv @@
// One cell of the divider chain: one quotient bit of each component per cycle while advance is high.
module v3n_div_cell (
   input  logic              clock,
   input  logic              advance,
   input  logic [31:0]       len_in,
   input  logic              deg_in,
   input  logic [50:0]       rx_in, ry_in, rz_in,
   input  logic [17:0]       qx_in, qy_in, qz_in,
   input  logic [2:0]        neg_in,
   output logic [31:0]       len_out,
   output logic              deg_out,
   output logic [50:0]       rx_out, ry_out, rz_out,
   output logic [17:0]       qx_out, qy_out, qz_out,
   output logic [2:0]        neg_out
);
   // Partial remainder sits in the 33-bit window [50:18]; the next numerator
   // bit waits at bit 17 and zeros follow behind it.
   logic [31:0] len_ff;
   logic        deg_ff;
   logic [50:0] rx_ff, ry_ff, rz_ff;
   logic [17:0] qx_ff, qy_ff, qz_ff;
   logic [2:0]  neg_ff;

   function automatic logic [68:0] dstep(input logic [50:0] r, input logic [17:0] q,
                                         input logic [31:0] d);
      logic [33:0] hi;
      logic [50:0] rn;
      logic [17:0] qn;
      hi = {r[50:18], 1'b0} | {33'd0, r[17]};
      rn = {r[49:0], 1'b0};
      qn = {q[16:0], 1'b0};
      if (hi >= {2'b00, d}) begin
         rn[50:18] = hi[32:0] - {1'b0, d};
         qn[0] = 1'b1;
      end else begin
         rn[50:18] = hi[32:0];
      end
      // saturate flag on q overflow into top
      if (q[17]) qn = 18'h3FFFF;
      return {rn, qn};
   endfunction

   logic [68:0] sx, sy, sz;
   always_comb begin
      sx = dstep(rx_in, qx_in, len_in);
      sy = dstep(ry_in, qy_in, len_in);
      sz = dstep(rz_in, qz_in, len_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff <= len_in;
         deg_ff <= deg_in;
         rx_ff <= sx[68:18]; qx_ff <= sx[17:0];
         ry_ff <= sy[68:18]; qy_ff <= sy[17:0];
         rz_ff <= sz[68:18]; qz_ff <= sz[17:0];
         neg_ff <= neg_in;
      end
   end
   assign len_out = len_ff;
   assign deg_out = deg_ff;
   assign rx_out = rx_ff; assign ry_out = ry_ff; assign rz_out = rz_ff;
   assign qx_out = qx_ff; assign qy_out = qy_ff; assign qz_out = qz_ff;
   assign neg_out = neg_ff;
endmodule

@@ rtl/vector3_normalize.sv @@
// Top level: pipelined 3D vector normalizer built from chains of cells.
//
// Usage:
//  - req channel carries x_in/y_in/z_in (signed Q16.16); one transfer per vector.
//  - rsp channel returns unit_x/y/z (Q1.16), length (Q16.16) and degenerate.
//  - csr port (APB-style) holds min_length at address 0; write only while idle.
// Throughput: one vector per cycle, back to back, while rsp is taken.
// Pipeline: a squaring stage, 32 root cells, 1 compare stage, FRAC_BITS+1
//  divide cells and the output register; the root and divide chains resolve
//  one bit per cell.
// Divider preloads half the magnitude (below the divisor unless degenerate), so only
//  FRAC_BITS+1 quotient bits are left to resolve.
// The whole pipeline advances together; when rsp stalls with a valid result
// at the output, the chain freezes and req.ready drops in the same cycle.
// Reset clears all valid bits and min_length; payload registers keep junk.
// Quotients above 131071 saturate to 131071 before the sign.
module vector3_normalize #(
   parameter int FRAC_BITS = v3n_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   v3n_req_if.sink     req,
   v3n_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import v3n_pkg::*;
   `include "vector3_normalize_defines.svh"

   localparam int NROOT = 32;
   localparam int NDIV  = FRAC_BITS + 1;
   localparam int DEPTH = 1 + NROOT + 1 + NDIV + 1;

   logic [MINLEN_W-1:0] min_len_ff;
   logic advance;
   logic [DEPTH-1:0] vld_ff, vld_in;

   // Config port: writes land on the access phase.
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == {REG_MIN_LENGTH, 1'b0}) begin
         min_len_ff <= csr_pwdata[MINLEN_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr == {REG_MIN_LENGTH, 1'b0}) ? {16'd0, min_len_ff} : '0;

   // Whole chain moves unless the output holds an untaken result.
   assign advance   = !(rsp.valid && !rsp.ready);
   assign req.ready = advance;
   assign vld_in    = {vld_ff[DEPTH-2:0], req.valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   // Stage 0: magnitudes and squares.
   vec_type vec0_ff;
   logic [63:0] sq_sum;
   logic [31:0] mx, my, mz;
   always_comb begin
      mx = req.x_in[31] ? 32'(-req.x_in) : 32'(req.x_in);
      my = req.y_in[31] ? 32'(-req.y_in) : 32'(req.y_in);
      mz = req.z_in[31] ? 32'(-req.z_in) : 32'(req.z_in);
   end
   logic [63:0] px_ff, py_ff, pz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         vec0_ff <= '{req.x_in[31], req.y_in[31], req.z_in[31], mx, my, mz};
         px_ff <= 64'(mx) * 64'(mx);
         py_ff <= 64'(my) * 64'(my);
         pz_ff <= 64'(mz) * 64'(mz);
      end
   end
   assign sq_sum = px_ff + py_ff + pz_ff;

   // Root chain (the products above feed the first cell via the sum).
   logic [63:0] rem_c [NROOT+1];
   logic [31:0] root_c [NROOT+1];
   vec_type     vec_c [NROOT+1];
   assign rem_c[0] = sq_sum;
   assign root_c[0] = '0;
   assign vec_c[0] = vec0_ff;
   for (genvar i = 0; i < NROOT; i++) begin : g_root
      v3n_sqrt_cell #(.STEP(i)) u_cell (
         .clock, .advance,
         .rem_in(rem_c[i]), .root_in(root_c[i]), .vec_in(vec_c[i]),
         .rem_out(rem_c[i+1]), .root_out(root_c[i+1]), .vec_out(vec_c[i+1]));
   end

   // Threshold compare stage.
   logic [31:0] len_ff;
   logic deg_ff;
   vec_type vecd_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff  <= root_c[NROOT];
         deg_ff  <= !(root_c[NROOT] > {16'd0, min_len_ff});
         vecd_ff <= vec_c[NROOT];
      end
   end

   // Divider chain.
   logic [31:0] dl [NDIV+1];
   logic        dd [NDIV+1];
   logic [50:0] rx [NDIV+1], ry [NDIV+1], rz [NDIV+1];
   logic [17:0] qx [NDIV+1], qy [NDIV+1], qz [NDIV+1];
   logic [2:0]  dn [NDIV+1];
   assign dl[0] = deg_ff ? 32'd1 : len_ff;
   assign dd[0] = deg_ff;
   // Window gets magnitude >> 1, its low bit waits just below the window.
   assign rx[0] = {19'd0, vecd_ff.mag_x} << 17;
   assign ry[0] = {19'd0, vecd_ff.mag_y} << 17;
   assign rz[0] = {19'd0, vecd_ff.mag_z} << 17;
   assign qx[0] = '0; assign qy[0] = '0; assign qz[0] = '0;
   assign dn[0] = {vecd_ff.neg_x, vecd_ff.neg_y, vecd_ff.neg_z};
   for (genvar j = 0; j < NDIV; j++) begin : g_div
      v3n_div_cell u_cell (
         .clock, .advance,
         .len_in(dl[j]), .deg_in(dd[j]),
         .rx_in(rx[j]), .ry_in(ry[j]), .rz_in(rz[j]),
         .qx_in(qx[j]), .qy_in(qy[j]), .qz_in(qz[j]),
         .neg_in(dn[j]),
         .len_out(dl[j+1]), .deg_out(dd[j+1]),
         .rx_out(rx[j+1]), .ry_out(ry[j+1]), .rz_out(rz[j+1]),
         .qx_out(qx[j+1]), .qy_out(qy[j+1]), .qz_out(qz[j+1]),
         .neg_out(dn[j+1]));
   end

   function automatic logic [17:0] fin(input logic [17:0] q, input logic n);
      logic [17:0] m;
      m = q[17] ? UNIT_MAX_MAG : q;
      return n ? 18'(-m) : m;
   endfunction

   logic [17:0] ux_ff, uy_ff, uz_ff;
   logic [31:0] lo_ff;
   logic        dg_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dg_ff <= dd[NDIV];
         lo_ff <= dd[NDIV] ? '0 : dl[NDIV];
         ux_ff <= dd[NDIV] ? '0 : fin(qx[NDIV], dn[NDIV][2]);
         uy_ff <= dd[NDIV] ? '0 : fin(qy[NDIV], dn[NDIV][1]);
         uz_ff <= dd[NDIV] ? '0 : fin(qz[NDIV], dn[NDIV][0]);
      end
   end
   assign rsp.valid      = vld_ff[DEPTH-1];
   assign rsp.unit_x     = ux_ff;
   assign rsp.unit_y     = uy_ff;
   assign rsp.unit_z     = uz_ff;
   assign rsp.length     = lo_ff;
   assign rsp.degenerate = dg_ff;

   `V3N_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   `V3N_ASSERT_IMP(a_deg_zero_len, clock, reset, rsp.valid && rsp.degenerate, rsp.length == 0)
   `V3N_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
endmodule
